// ===== rtl/rlt_pkg.sv =====
// rlt_pkg: shared types and codes for the record reader/writer lock table
// depends on nothing; used by every file in rtl
package rlt_pkg;

	localparam int RIU_W = 7;

	typedef enum logic [2:0] {
		REQ_READ_START = 3'd0,
		REQ_READ_DONE  = 3'd1,
		REQ_WRITE_LOCK = 3'd2,
		REQ_COMMIT     = 3'd3,
		REQ_UNLOCK     = 3'd4,
		REQ_EXIT       = 3'd5,
		REQ_LOAD       = 3'd6
	} req_type_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_BUSY      = 2'd2,
		STAT_PROTOCOL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic [63:0]        name_low;
		logic [15:0]        name_high;
		logic [63:0]        hours;
	} rec_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] key;
		logic [31:0]        client_id;
		logic [5:0]         load_index;
		rec_t               data;
	} req_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

// ===== rtl/rlt_if.sv =====
// rlt_if: valid/ready channels of the lock table (config, request, result)
// depends on rlt_pkg
interface rlt_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [rlt_pkg::RIU_W-1:0]   records_in_use;

	modport source (output valid, output records_in_use, input ready);
	modport sink (input valid, input records_in_use, output ready);
endinterface

interface rlt_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic signed [31:0] key;
	logic [31:0]        client_id;
	logic [5:0]         load_index;
	logic signed [31:0] new_key;
	logic [63:0]        new_name_low;
	logic [15:0]        new_name_high;
	logic [63:0]        new_hours;

	modport source (output valid, output req_type, output key, output client_id,
		output load_index, output new_key, output new_name_low, output new_name_high,
		output new_hours, input ready);
	modport sink (input valid, input req_type, input key, input client_id,
		input load_index, input new_key, input new_name_low, input new_name_high,
		input new_hours, output ready);
endinterface

interface rlt_resp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] out_key;
	logic [63:0]        out_name_low;
	logic [15:0]        out_name_high;
	logic [63:0]        out_hours;

	modport source (output valid, output status, output out_key, output out_name_low,
		output out_name_high, output out_hours, input ready);
	modport sink (input valid, input status, input out_key, input out_name_low,
		input out_name_high, input out_hours, output ready);
endinterface

// ===== rtl/record_reader_writer_lock_table.sv =====
// record_reader_writer_lock_table: top level of the record lock table
// depends on rlt_pkg, rlt_if, rlt_rec_mem, rlt_lock_mem, rlt_ctrl
//
// Channels: cfg writes records_in_use (always ready); req takes one request
// item; resp returns exactly one result item per request, in order.
// A request scans the record memory from entry 0, one entry per cycle, over
// min(records_in_use, TABLE_ENTRIES) entries, stopping at the first key match.
// The record memory has one read port, so the scan sets the latency; a load
// or an empty span skips the scan and goes straight to the result.
// One request is worked on at a time; req is ready again in the cycle after
// its result is written to the output register, so the next request can be
// accepted while that result still waits on resp.
// If resp stalls, the finished result holds and the block waits before
// writing back lock state, so nothing is lost.
// Reset: a clearing pass over every entry zeroes reader counts and owners;
// req stays low meanwhile, cfg writes are taken. Record contents are
// undefined until loaded.
module record_reader_writer_lock_table #(
	parameter int TABLE_ENTRIES = 64,
	parameter int READER_LIMIT = 255
) (
	input logic         clk,
	input logic         arst_n,
	rlt_cfg_if.sink     cfg,
	rlt_req_if.sink     req,
	rlt_resp_if.source  resp
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int RW = $clog2(READER_LIMIT + 1);

	rlt_pkg::mem_ctl_t rec_ctl;
	rlt_pkg::mem_ctl_t lock_ctl;
	logic [IW-1:0]     rec_rd_addr;
	logic [IW-1:0]     rec_wr_addr;
	rlt_pkg::rec_t     rec_wr_data;
	rlt_pkg::rec_t     rec_rd_data;
	logic [IW-1:0]     lock_rd_addr;
	logic [IW-1:0]     lock_wr_addr;
	logic [RW-1:0]     lock_wr_count;
	logic [31:0]       lock_wr_owner;
	logic [RW-1:0]     lock_rd_count;
	logic [31:0]       lock_rd_owner;

	rlt_rec_mem #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_rec_mem (
		.clk     (clk),
		.ctl     (rec_ctl),
		.rd_addr (rec_rd_addr),
		.rd_data (rec_rd_data),
		.wr_addr (rec_wr_addr),
		.wr_data (rec_wr_data)
	);

	rlt_lock_mem #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.READER_LIMIT (READER_LIMIT)
	) u_lock_mem (
		.clk      (clk),
		.ctl      (lock_ctl),
		.rd_addr  (lock_rd_addr),
		.rd_count (lock_rd_count),
		.rd_owner (lock_rd_owner),
		.wr_addr  (lock_wr_addr),
		.wr_count (lock_wr_count),
		.wr_owner (lock_wr_owner)
	);

	rlt_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.READER_LIMIT (READER_LIMIT)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.req           (req),
		.resp          (resp),
		.rec_ctl       (rec_ctl),
		.rec_rd_addr   (rec_rd_addr),
		.rec_wr_addr   (rec_wr_addr),
		.rec_wr_data   (rec_wr_data),
		.rec_rd_data   (rec_rd_data),
		.lock_ctl      (lock_ctl),
		.lock_rd_addr  (lock_rd_addr),
		.lock_wr_addr  (lock_wr_addr),
		.lock_wr_count (lock_wr_count),
		.lock_wr_owner (lock_wr_owner),
		.lock_rd_count (lock_rd_count),
		.lock_rd_owner (lock_rd_owner)
	);

endmodule

// ===== rtl/rlt_rec_mem.sv =====
// rlt_rec_mem: record memory (key, name, hours), one write and one read port
// registered read data; depends on rlt_pkg
module rlt_rec_mem #(
	parameter int TABLE_ENTRIES = 64,
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic              clk,
	input  rlt_pkg::mem_ctl_t ctl,
	input  logic [IW-1:0]     rd_addr,
	output rlt_pkg::rec_t     rd_data,
	input  logic [IW-1:0]     wr_addr,
	input  rlt_pkg::rec_t     wr_data
);

	rlt_pkg::rec_t mem [TABLE_ENTRIES];
	rlt_pkg::rec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/rlt_lock_mem.sv =====
// rlt_lock_mem: per-entry lock state (reader count, writer owner)
// one write and one read port, registered read data; depends on rlt_pkg
module rlt_lock_mem #(
	parameter int TABLE_ENTRIES = 64,
	parameter int READER_LIMIT = 255,
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int RW = $clog2(READER_LIMIT + 1)
) (
	input  logic              clk,
	input  rlt_pkg::mem_ctl_t ctl,
	input  logic [IW-1:0]     rd_addr,
	output logic [RW-1:0]     rd_count,
	output logic [31:0]       rd_owner,
	input  logic [IW-1:0]     wr_addr,
	input  logic [RW-1:0]     wr_count,
	input  logic [31:0]       wr_owner
);

	logic [RW+31:0] mem [TABLE_ENTRIES];
	logic [RW+31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= {wr_count, wr_owner};
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_count = rd_data_q[RW+31:32];
	assign rd_owner = rd_data_q[31:0];

endmodule

// ===== rtl/rlt_ctrl.sv =====
// rlt_ctrl: sequencer of the lock table: clear pass, key scan, lock decision,
// write-back and result register; depends on rlt_pkg and rlt_if
module rlt_ctrl #(
	parameter int TABLE_ENTRIES = 64,
	parameter int READER_LIMIT = 255,
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int CW = $clog2(TABLE_ENTRIES + 1),
	localparam int RW = $clog2(READER_LIMIT + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	rlt_cfg_if.sink           cfg,
	rlt_req_if.sink           req,
	rlt_resp_if.source        resp,
	output rlt_pkg::mem_ctl_t rec_ctl,
	output logic [IW-1:0]     rec_rd_addr,
	output logic [IW-1:0]     rec_wr_addr,
	output rlt_pkg::rec_t     rec_wr_data,
	input  rlt_pkg::rec_t     rec_rd_data,
	output rlt_pkg::mem_ctl_t lock_ctl,
	output logic [IW-1:0]     lock_rd_addr,
	output logic [IW-1:0]     lock_wr_addr,
	output logic [RW-1:0]     lock_wr_count,
	output logic [31:0]       lock_wr_owner,
	input  logic [RW-1:0]     lock_rd_count,
	input  logic [31:0]       lock_rd_owner
);

	localparam int SW = (CW > rlt_pkg::RIU_W) ? CW : rlt_pkg::RIU_W;

	rlt_pkg::state_t state_q, state_d;
	logic [CW-1:0]              cnt_q;
	logic [IW-1:0]              idx_s1;
	logic                       pend_s1;
	logic [IW-1:0]              hit_idx_q;
	logic                       found_q;
	rlt_pkg::req_t              req_q;
	logic [rlt_pkg::RIU_W-1:0]  riu_q;
	logic                       out_valid_q;
	rlt_pkg::status_t           out_status_q;
	rlt_pkg::rec_t              out_rec_q;

	logic [SW-1:0]    riu_ext;
	logic [CW-1:0]    span;
	logic             accept;
	logic             match;
	logic             issue;
	logic             out_free;
	logic             fire;
	logic             load_ok;
	logic             owns;
	rlt_pkg::status_t res_status;
	logic             res_give;

	assign riu_ext  = SW'(riu_q);
	assign span     = (riu_ext > SW'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES) : CW'(riu_ext);
	assign accept   = req.valid && req.ready;
	assign match    = pend_s1 && (rec_rd_data.key == req_q.key);
	assign issue    = (state_q == rlt_pkg::S_SCAN) && (cnt_q < span) && !match;
	assign out_free = !out_valid_q || resp.ready;
	assign fire     = (state_q == rlt_pkg::S_DONE) && out_free;
	assign load_ok  = 32'(req_q.load_index) < 32'(TABLE_ENTRIES);
	assign owns     = (req_q.client_id != 32'd0) && (lock_rd_owner == req_q.client_id);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rlt_pkg::S_CLEAR: begin
				if (cnt_q == CW'(TABLE_ENTRIES - 1)) begin
					state_d = rlt_pkg::S_IDLE;
				end
			end
			rlt_pkg::S_IDLE: begin
				if (req.valid) begin
					if (req.req_type == rlt_pkg::REQ_LOAD || span == '0) begin
						state_d = rlt_pkg::S_DONE;
					end else begin
						state_d = rlt_pkg::S_SCAN;
					end
				end
			end
			rlt_pkg::S_SCAN: begin
				if (match || cnt_q == span) begin
					state_d = rlt_pkg::S_DONE;
				end
			end
			rlt_pkg::S_DONE: begin
				if (out_free) begin
					state_d = rlt_pkg::S_IDLE;
				end
			end
		endcase
	end

	// decision, memory controls
	always_comb begin
		res_status    = rlt_pkg::STAT_OK;
		res_give      = 1'b0;
		rec_ctl       = '0;
		lock_ctl      = '0;
		rec_rd_addr   = cnt_q[IW-1:0];
		rec_wr_addr   = hit_idx_q;
		rec_wr_data   = req_q.data;
		lock_rd_addr  = idx_s1;
		lock_wr_addr  = hit_idx_q;
		lock_wr_count = lock_rd_count;
		lock_wr_owner = lock_rd_owner;
		rec_ctl.rd_en  = issue;
		lock_ctl.rd_en = (state_q == rlt_pkg::S_SCAN) && match;

		if (state_q == rlt_pkg::S_CLEAR) begin
			lock_ctl.wr_en = 1'b1;
			lock_wr_addr   = cnt_q[IW-1:0];
			lock_wr_count  = '0;
			lock_wr_owner  = '0;
		end

		if (req_q.req_type == rlt_pkg::REQ_LOAD) begin
			rec_wr_addr = IW'(req_q.load_index);
			if (load_ok) begin
				rec_ctl.wr_en = fire;
			end else begin
				res_status = rlt_pkg::STAT_PROTOCOL;
			end
		end else if (!found_q) begin
			res_status = rlt_pkg::STAT_NOT_FOUND;
		end else begin
			unique case (req_q.req_type)
				rlt_pkg::REQ_READ_START: begin
					if (lock_rd_owner != 32'd0 || lock_rd_count >= RW'(READER_LIMIT)) begin
						res_status = rlt_pkg::STAT_BUSY;
					end else begin
						res_give       = 1'b1;
						lock_wr_count  = RW'(lock_rd_count + 1'b1);
						lock_ctl.wr_en = fire;
					end
				end
				rlt_pkg::REQ_READ_DONE: begin
					if (lock_rd_count != '0) begin
						lock_wr_count  = RW'(lock_rd_count - 1'b1);
						lock_ctl.wr_en = fire;
					end else begin
						res_status = rlt_pkg::STAT_PROTOCOL;
					end
				end
				rlt_pkg::REQ_WRITE_LOCK: begin
					if (lock_rd_count != '0 || lock_rd_owner != 32'd0) begin
						res_status = rlt_pkg::STAT_BUSY;
					end else if (req_q.client_id == 32'd0) begin
						res_status = rlt_pkg::STAT_PROTOCOL;
					end else begin
						res_give       = 1'b1;
						lock_wr_owner  = req_q.client_id;
						lock_ctl.wr_en = fire;
					end
				end
				rlt_pkg::REQ_COMMIT: begin
					if (owns) begin
						rec_ctl.wr_en = fire;
					end else begin
						res_status = rlt_pkg::STAT_PROTOCOL;
					end
				end
				rlt_pkg::REQ_UNLOCK: begin
					if (owns) begin
						lock_wr_owner  = '0;
						lock_ctl.wr_en = fire;
					end else begin
						res_status = rlt_pkg::STAT_PROTOCOL;
					end
				end
				rlt_pkg::REQ_EXIT: begin
					res_status = rlt_pkg::STAT_OK;
				end
				default: begin
					res_status = rlt_pkg::STAT_PROTOCOL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rlt_pkg::S_CLEAR;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			riu_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (cfg.valid) begin
				riu_q <= cfg.records_in_use;
			end
			if (accept) begin
				cnt_q <= '0;
			end else if (issue || state_q == rlt_pkg::S_CLEAR) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (accept) begin
				found_q <= 1'b0;
			end else if (match) begin
				found_q <= 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (resp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IW-1:0];
		if (match) begin
			hit_idx_q <= idx_s1;
		end
		if (accept) begin
			req_q.req_type       <= req.req_type;
			req_q.key            <= req.key;
			req_q.client_id      <= req.client_id;
			req_q.load_index     <= req.load_index;
			req_q.data.key       <= req.new_key;
			req_q.data.name_low  <= req.new_name_low;
			req_q.data.name_high <= req.new_name_high;
			req_q.data.hours     <= req.new_hours;
		end
		if (fire) begin
			out_status_q <= res_status;
			out_rec_q    <= res_give ? rec_rd_data : '0;
		end
	end

	assign cfg.ready          = 1'b1;
	assign req.ready          = (state_q == rlt_pkg::S_IDLE);
	assign resp.valid         = out_valid_q;
	assign resp.status        = out_status_q;
	assign resp.out_key       = out_rec_q.key;
	assign resp.out_name_low  = out_rec_q.name_low;
	assign resp.out_name_high = out_rec_q.name_high;
	assign resp.out_hours     = out_rec_q.hours;

endmodule

// ===== rtl/rlt_checker.sv =====
// rlt_checker: port-level checks of the lock table, bound to the top level
// depends on rlt_pkg and record_reader_writer_lock_table
module rlt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               resp_valid,
	input logic               resp_ready,
	input logic [1:0]         status,
	input logic signed [31:0] out_key,
	input logic [63:0]        out_name_low,
	input logic [15:0]        out_name_high,
	input logic [63:0]        out_hours
);

	logic [2:0] open_q;
	logic       req_acc;
	logic       resp_acc;

	assign req_acc  = req_valid && req_ready;
	assign resp_acc = resp_valid && resp_ready;

	// items accepted whose result is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (req_acc && !resp_acc) begin
			open_q <= open_q + 1'b1;
		end else if (resp_acc && !req_acc) begin
			open_q <= open_q - 1'b1;
		end
	end

	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid |-> open_q != 3'd0)
		else $error("result item without an open request");

	a_open_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 3'd2)
		else $error("more than two items in flight");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request taken while another is in work");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && status != rlt_pkg::STAT_OK |->
			out_key == 32'sd0 && out_name_low == 64'd0 &&
			out_name_high == 16'd0 && out_hours == 64'd0)
		else $error("record data on a failed request");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && !resp_ready |=> resp_valid && $stable(status))
		else $error("stalled result changed");

endmodule

bind record_reader_writer_lock_table rlt_checker u_rlt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.resp_valid    (resp.valid),
	.resp_ready    (resp.ready),
	.status        (resp.status),
	.out_key       (resp.out_key),
	.out_name_low  (resp.out_name_low),
	.out_name_high (resp.out_name_high),
	.out_hours     (resp.out_hours)
);

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for the record reader/writer lock table
// drives requests and table sizes, predicts every reply and compares it field by field
// depends on rlt_pkg, rlt_if and record_reader_writer_lock_table
module tb_top;

	localparam int TABLE_N = 64;
	localparam int READER_MAX = 255;
	localparam int POOL_N = 12;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam logic [2:0] REQ_UNDEFINED = 3'd7;
	localparam logic [31:0] MIN_KEY = 32'h8000_0000;
	localparam logic [31:0] TOP_KEY = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_KEY = 32'h5A5A_0001;
	localparam logic [31:0] MISS_KEY = 32'h1234_5679;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		rlt_pkg::status_t status;
		rlt_pkg::rec_t    data;
	} lock_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rlt_cfg_if cfg ();
	rlt_req_if req ();
	rlt_resp_if resp ();

	record_reader_writer_lock_table #(
		.TABLE_ENTRIES(TABLE_N),
		.READER_LIMIT(READER_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.resp(resp)
	);

	// table mirror
	rlt_pkg::rec_t store_rec [TABLE_N];
	logic [7:0]    rd_cnt [TABLE_N];
	logic [31:0]   owner [TABLE_N];
	logic [6:0]    span = '0;

	rlt_pkg::req_t pending_reqs [$];
	lock_reply_t   expected_replies [$];
	logic [31:0]   key_pool [POOL_N];
	rlt_pkg::req_t drive_item;
	int          queued_total = 0;
	int          req_count = 0;
	int          send_idle_pct = 9;
	int          recv_idle_pct = 68;
	int          hold_ask = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	logic        req_took = 1'b0;
	logic        cfg_took = 1'b0;
	bit          failed = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic lock_reply_t serve_request(rlt_pkg::req_t r);
		lock_reply_t ans;
		int hit;
		int lim;
		ans.status = rlt_pkg::STAT_OK;
		ans.data = '0;
		if (r.req_type == rlt_pkg::REQ_LOAD) begin
			store_rec[r.load_index] = r.data;
			return ans;
		end
		lim = (span > TABLE_N) ? TABLE_N : span;
		hit = -1;
		for (int j = lim - 1; j >= 0; j--)
			if (store_rec[j].key == r.key)
				hit = j;
		if (hit < 0) begin
			ans.status = rlt_pkg::STAT_NOT_FOUND;
			return ans;
		end
		case (r.req_type)
			rlt_pkg::REQ_READ_START: begin
				if (owner[hit] != 0 || rd_cnt[hit] >= READER_MAX) begin
					ans.status = rlt_pkg::STAT_BUSY;
				end else begin
					rd_cnt[hit]++;
					ans.data = store_rec[hit];
				end
			end
			rlt_pkg::REQ_READ_DONE: begin
				if (rd_cnt[hit] != 0)
					rd_cnt[hit]--;
				else
					ans.status = rlt_pkg::STAT_PROTOCOL;
			end
			rlt_pkg::REQ_WRITE_LOCK: begin
				if (rd_cnt[hit] != 0 || owner[hit] != 0) begin
					ans.status = rlt_pkg::STAT_BUSY;
				end else if (r.client_id == 0) begin
					ans.status = rlt_pkg::STAT_PROTOCOL;
				end else begin
					owner[hit] = r.client_id;
					ans.data = store_rec[hit];
				end
			end
			rlt_pkg::REQ_COMMIT: begin
				if (r.client_id != 0 && owner[hit] == r.client_id)
					store_rec[hit] = r.data;
				else
					ans.status = rlt_pkg::STAT_PROTOCOL;
			end
			rlt_pkg::REQ_UNLOCK: begin
				if (r.client_id != 0 && owner[hit] == r.client_id)
					owner[hit] = '0;
				else
					ans.status = rlt_pkg::STAT_PROTOCOL;
			end
			rlt_pkg::REQ_EXIT: begin
				ans.status = rlt_pkg::STAT_OK;
			end
			default: begin
				ans.status = rlt_pkg::STAT_PROTOCOL;
			end
		endcase
		return ans;
	endfunction

	task automatic check_reply();
		lock_reply_t want;
		if (expected_replies.size() == 0) begin
			failed = 1'b1;
			$display("%0t: unexpected result, status %0d key %h", $time,
				resp.status, resp.out_key);
		end else begin
			want = expected_replies.pop_front();
			if (resp.status !== want.status || resp.out_key !== want.data.key ||
				resp.out_name_low !== want.data.name_low ||
				resp.out_name_high !== want.data.name_high ||
				resp.out_hours !== want.data.hours) begin
				failed = 1'b1;
				$display("%0t: mismatch, expected status %0d key %h name %h_%h hours %h",
					$time, want.status, want.data.key, want.data.name_high,
					want.data.name_low, want.data.hours);
				$display("%0t:           actual status %0d key %h name %h_%h hours %h",
					$time, resp.status, resp.out_key, resp.out_name_high,
					resp.out_name_low, resp.out_hours);
			end
		end
	endtask

	// monitor: checks replies, tracks table size, predicts each accepted item
	always @(posedge clk) begin : monitor
		rlt_pkg::req_t taken;
		lock_reply_t   reply;
		req_took <= arst_n && req.valid && req.ready;
		cfg_took <= arst_n && cfg.valid && cfg.ready;
		if (arst_n) begin
			if (resp.valid && resp.ready)
				check_reply();
			if (cfg.valid && cfg.ready)
				span = cfg.records_in_use;
			if (req.valid && req.ready) begin
				taken.req_type = req.req_type;
				taken.key = req.key;
				taken.client_id = req.client_id;
				taken.load_index = req.load_index;
				taken.data.key = req.new_key;
				taken.data.name_low = req.new_name_low;
				taken.data.name_high = req.new_name_high;
				taken.data.hours = req.new_hours;
				reply = serve_request(taken);
				expected_replies = {expected_replies, reply};
				req_count++;
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req_took) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drive_item = pending_reqs.pop_front();
				req.valid <= 1'b1;
				req.req_type <= drive_item.req_type;
				req.key <= drive_item.key;
				req.client_id <= drive_item.client_id;
				req.load_index <= drive_item.load_index;
				req.new_key <= drive_item.data.key;
				req.new_name_low <= drive_item.data.name_low;
				req.new_name_high <= drive_item.data.name_high;
				req.new_hours <= drive_item.data.hours;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// reply receiver with one long hold-off
	always @(negedge clk) begin
		if (hold_seen != hold_ask) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			resp.ready <= 1'b0;
		end else begin
			resp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (resp.valid && resp.ready) ||
			(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(99);
		if (sel < 85)
			return key_pool[$urandom_range(POOL_N - 1)];
		if (sel < 95)
			return $urandom;
		return TOP_KEY;
	endfunction

	function automatic logic [31:0] pick_client();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return ALL_ONES;
		if (sel == 2)
			return $urandom;
		return $urandom_range(4, 1);
	endfunction

	function automatic rlt_pkg::req_t make_req(logic [2:0] op, logic [31:0] k,
		logic [31:0] who);
		rlt_pkg::req_t r;
		r.req_type = op;
		r.key = k;
		r.client_id = who;
		r.load_index = 6'($urandom_range(TABLE_N - 1));
		r.data.key = pick_key();
		r.data.name_low = {$urandom, $urandom};
		r.data.name_high = 16'($urandom);
		r.data.hours = {$urandom, $urandom};
		return r;
	endfunction

	function automatic void put(rlt_pkg::req_t r);
		pending_reqs = {pending_reqs, r};
		queued_total++;
	endfunction

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || req.valid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_span(logic [6:0] v);
		wait_idle();
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.records_in_use <= v;
		do
			@(negedge clk);
		while (!cfg_took);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// reader visits, writer lock/commit/unlock runs, loads and noise
	task automatic add_random(int n);
		int target;
		int sel;
		logic [31:0] k;
		logic [31:0] c;
		rlt_pkg::req_t r;
		target = queued_total + n;
		while (queued_total < target) begin
			sel = $urandom_range(99);
			k = pick_key();
			c = pick_client();
			if (sel < 38) begin
				put(make_req(rlt_pkg::REQ_READ_START, k, c));
				if ($urandom_range(2) == 0)
					put(make_req(3'($urandom_range(7)), pick_key(), pick_client()));
				put(make_req(rlt_pkg::REQ_READ_DONE, k, c));
			end else if (sel < 76) begin
				put(make_req(rlt_pkg::REQ_WRITE_LOCK, k, c));
				if ($urandom_range(3) == 0)
					put(make_req(rlt_pkg::REQ_READ_START, k, pick_client()));
				r = make_req(rlt_pkg::REQ_COMMIT, k, c);
				if ($urandom_range(9) < 7)
					r.data.key = k;
				put(r);
				if ($urandom_range(4) == 0)
					put(make_req(rlt_pkg::REQ_UNLOCK, r.data.key, pick_client()));
				put(make_req(rlt_pkg::REQ_UNLOCK, r.data.key, c));
			end else if (sel < 86) begin
				put(make_req(rlt_pkg::REQ_LOAD, k, c));
			end else begin
				put(make_req(3'($urandom_range(7)), k, c));
			end
		end
	endtask

	// fill entry 0 to the reader limit and drain it again
	task automatic saturate_readers();
		rlt_pkg::req_t r;
		wait_idle();
		if (owner[0] != 0)
			put(make_req(rlt_pkg::REQ_UNLOCK, store_rec[0].key, owner[0]));
		r = make_req(rlt_pkg::REQ_LOAD, SAT_KEY, 1);
		r.load_index = '0;
		r.data.key = SAT_KEY;
		put(r);
		repeat (256 - rd_cnt[0])
			put(make_req(rlt_pkg::REQ_READ_START, SAT_KEY, pick_client()));
		repeat (256)
			put(make_req(rlt_pkg::REQ_READ_DONE, SAT_KEY, pick_client()));
	endtask

	initial begin
		rlt_pkg::req_t r;
		int base;
		for (int e = 0; e < TABLE_N; e++) begin
			store_rec[e] = '0;
			rd_cnt[e] = '0;
			owner[e] = '0;
		end
		key_pool[0] = MIN_KEY;
		key_pool[1] = '0;
		key_pool[2] = ALL_ONES;
		for (int p = 3; p < POOL_N; p++)
			key_pool[p] = $urandom;
		req.valid = 1'b0;
		req.req_type = '0;
		req.key = '0;
		req.client_id = '0;
		req.load_index = '0;
		req.new_key = '0;
		req.new_name_low = '0;
		req.new_name_high = '0;
		req.new_hours = '0;
		cfg.valid = 1'b0;
		cfg.records_in_use = '0;
		resp.ready = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty search span: nothing is found
		write_span(7'd0);
		for (int op = 0; op < 8; op++)
			put(make_req(3'(op), MIN_KEY, 1));

		// load every entry before any search can reach it
		for (int e = 0; e < TABLE_N; e++) begin
			r = make_req(rlt_pkg::REQ_LOAD, MIN_KEY, 1);
			r.load_index = 6'(e);
			r.data.key = (e == TABLE_N - 1) ? TOP_KEY : key_pool[e % POOL_N];
			if (e == 1) begin
				r.data.name_low = '0;
				r.data.name_high = '0;
				r.data.hours = '0;
			end
			if (e == 2) begin
				r.data.name_low = '1;
				r.data.name_high = '1;
				r.data.hours = '1;
			end
			put(r);
		end

		write_span(7'd64);
		put(make_req(rlt_pkg::REQ_READ_START, MIN_KEY, 1));
		put(make_req(rlt_pkg::REQ_WRITE_LOCK, MIN_KEY, 2));
		put(make_req(rlt_pkg::REQ_READ_DONE, MIN_KEY, 1));
		put(make_req(rlt_pkg::REQ_READ_DONE, MIN_KEY, 1));
		put(make_req(rlt_pkg::REQ_WRITE_LOCK, MIN_KEY, 0));
		put(make_req(rlt_pkg::REQ_WRITE_LOCK, MIN_KEY, ALL_ONES));
		put(make_req(rlt_pkg::REQ_READ_START, MIN_KEY, 1));
		put(make_req(rlt_pkg::REQ_WRITE_LOCK, MIN_KEY, 2));
		put(make_req(rlt_pkg::REQ_COMMIT, MIN_KEY, 2));
		put(make_req(rlt_pkg::REQ_COMMIT, MIN_KEY, 0));
		put(make_req(rlt_pkg::REQ_UNLOCK, MIN_KEY, 0));
		r = make_req(rlt_pkg::REQ_COMMIT, MIN_KEY, ALL_ONES);
		r.data = '1;
		r.data.key = MIN_KEY;
		put(r);
		put(make_req(rlt_pkg::REQ_UNLOCK, MIN_KEY, ALL_ONES));
		put(make_req(rlt_pkg::REQ_READ_START, MIN_KEY, 1));
		put(make_req(rlt_pkg::REQ_READ_DONE, MIN_KEY, 1));
		put(make_req(rlt_pkg::REQ_EXIT, MIN_KEY, 3));
		put(make_req(rlt_pkg::REQ_EXIT, MISS_KEY, 3));
		put(make_req(REQ_UNDEFINED, MIN_KEY, 3));
		put(make_req(REQ_UNDEFINED, MISS_KEY, 3));
		put(make_req(rlt_pkg::REQ_READ_START, TOP_KEY, 4));
		put(make_req(rlt_pkg::REQ_READ_DONE, TOP_KEY, 4));
		r = make_req(rlt_pkg::REQ_LOAD, TOP_KEY, 4);
		r.load_index = 6'(TABLE_N - 1);
		r.data = '0;
		r.data.key = TOP_KEY;
		put(r);

		// span beyond the table size searches the whole table
		write_span(7'd127);
		put(make_req(rlt_pkg::REQ_READ_START, TOP_KEY, 4));
		put(make_req(rlt_pkg::REQ_READ_DONE, TOP_KEY, 4));
		add_random(220);
		base = req_count;
		while (req_count < base + 20)
			@(posedge clk);
		hold_ask++;

		write_span(7'd1);
		send_idle_pct = 68;
		recv_idle_pct = 9;
		add_random(80);
		write_span(7'd23);
		add_random(150);

		write_span(7'd64);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		saturate_readers();
		write_span(7'($urandom_range(127, 2)));
		add_random(45);
		wait_idle();
		add_random(45);

		wait_idle();
		repeat (70) @(posedge clk);
		if (!failed)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
